// File: rtl/tmf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tmf_pkg;

    localparam int SAMPLE_BITS    = 10;
    localparam int TAG_BITS       = 3;
    localparam int RESULT_BITS    = 10;
    localparam int WIN_BITS       = 7;
    localparam int DEF_MAX_WINDOW = 64;
    localparam int MIN_WINDOW     = 3;
    localparam int APB_ADDR_BITS  = 3;
    localparam int APB_DATA_BITS  = 32;

    localparam logic [WIN_BITS-1:0] WIN_RESET = 7'd8;

    // Register index decoded from paddr[2].
    localparam logic REG_WINDOW_SAMPLES = 1'b0;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample_value;
        logic [TAG_BITS-1:0]    channel_tag;
    } in_item_t;

    typedef struct packed {
        logic [RESULT_BITS-1:0] filtered_value;
        logic [TAG_BITS-1:0]    result_tag;
    } out_item_t;

    typedef struct packed {
        logic start;
        logic done;
        logic busy;
    } div_status_t;

endpackage

`default_nettype wire

// File: rtl/trimmed_mean_sample_filter_core.sv
// Trimmed-mean sample filter. Each request carries one sample and a channel tag; once the
// configured number of samples (window_samples, clamped to 3..MAX_WINDOW) has been taken, the
// smallest and largest are dropped and the remaining sum is divided by the count minus two,
// giving one result with the tag of the last sample. A sample that does not close the window
// is accepted without stalling. Once a closing sample is accepted, in_stall stays high through
// the two trim steps, the divide step and the output step; the divide step is the bit-serial
// restoring divider, which produces one quotient bit per cycle; a further delay follows only
// while an earlier result is still stalled at the output. window_samples is at byte address 0.
`timescale 1ns / 1ps
`default_nettype none

module trimmed_mean_sample_filter_core
    import tmf_pkg::*;
#(
    parameter int MAX_WINDOW = DEF_MAX_WINDOW
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [APB_ADDR_BITS-1:0] paddr,
    input  wire logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0]      prdata,
    output logic                          pready,
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire in_item_t                 in_item,
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output out_item_t                     out_item
);

    localparam int CW = $clog2(MAX_WINDOW + 1);
    localparam int SW = SAMPLE_BITS + $clog2(MAX_WINDOW);
    localparam int EW = (CW > WIN_BITS) ? CW : WIN_BITS;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_TRIM_MIN = 3'd1;
    localparam logic [2:0] ST_TRIM_MAX = 3'd2;
    localparam logic [2:0] ST_DIV      = 3'd3;
    localparam logic [2:0] ST_OUT      = 3'd4;

    logic [2:0]             state_reg;
    logic [2:0]             state_next;
    logic [WIN_BITS-1:0]    window_reg;
    logic [SW-1:0]          sum_reg;
    logic [SW-1:0]          sum_next;
    logic [SAMPLE_BITS-1:0] min_reg;
    logic [SAMPLE_BITS-1:0] min_next;
    logic [SAMPLE_BITS-1:0] max_reg;
    logic [SAMPLE_BITS-1:0] max_next;
    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          count_next;
    logic [CW-1:0]          count_inc;
    logic [TAG_BITS-1:0]    tag_reg;
    logic [RESULT_BITS-1:0] quo_hold_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    out_item_t              out_item_reg;
    logic [EW-1:0]          win_ext;
    logic [EW-1:0]          eff_window;
    logic                   in_accept;
    logic                   cfg_write;
    logic                   out_free;
    logic                   div_start;
    logic [SW-1:0]          div_dividend;
    logic [CW-1:0]          div_divisor;
    logic [SW-1:0]          div_quotient;
    div_status_t            div_status;

    // Configuration register.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_WINDOW_SAMPLES);
    assign prdata    = (paddr[2] == REG_WINDOW_SAMPLES) ?
                       APB_DATA_BITS'(window_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= WIN_RESET;
        end
        else if (cfg_write)
        begin
            window_reg <= pwdata[WIN_BITS-1:0];
        end
    end

    assign win_ext = EW'(window_reg);

    always_comb
    begin
        if (win_ext < EW'(MIN_WINDOW))
        begin
            eff_window = EW'(MIN_WINDOW);
        end
        else if (win_ext > EW'(MAX_WINDOW))
        begin
            eff_window = EW'(MAX_WINDOW);
        end
        else
        begin
            eff_window = win_ext;
        end
    end

    // Sequencer.
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign count_inc = count_reg + 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;

    assign div_start    = (state_reg == ST_TRIM_MAX);
    assign div_dividend = sum_reg - SW'(max_reg);
    assign div_divisor  = count_reg - CW'(2);

    always_comb
    begin
        state_next     = state_reg;
        sum_next       = sum_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    sum_next   = sum_reg + SW'(in_item.sample_value);
                    count_next = count_inc;
                    if (count_reg == '0)
                    begin
                        min_next = in_item.sample_value;
                        max_next = in_item.sample_value;
                    end
                    else
                    begin
                        if (in_item.sample_value < min_reg)
                        begin
                            min_next = in_item.sample_value;
                        end
                        if (in_item.sample_value > max_reg)
                        begin
                            max_next = in_item.sample_value;
                        end
                    end
                    if (EW'(count_inc) >= eff_window)
                    begin
                        state_next = ST_TRIM_MIN;
                    end
                end
            end
            ST_TRIM_MIN:
            begin
                sum_next   = sum_reg - SW'(min_reg);
                state_next = ST_TRIM_MAX;
            end
            ST_TRIM_MAX:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_status.done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    sum_next       = '0;
                    min_next       = '0;
                    max_next       = '0;
                    count_next     = '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sum_reg       <= '0;
            min_reg       <= '0;
            max_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            tag_reg <= in_item.channel_tag;
        end
        if (state_reg == ST_DIV && div_status.done)
        begin
            quo_hold_reg <= div_quotient[RESULT_BITS-1:0];
        end
        if (state_reg == ST_OUT && out_free)
        begin
            out_item_reg.filtered_value <= quo_hold_reg;
            out_item_reg.result_tag     <= tag_reg;
        end
    end

    tmf_divider #(
        .DW (SW),
        .VW (CW)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .status   (div_status),
        .quotient (div_quotient)
    );

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    a_out_from_seq : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_OUT))
        else $error("result raised outside the output step");

    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_WINDOW))
        else $error("sample count beyond the largest window");

    a_min_max : assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) |-> (min_reg <= max_reg))
        else $error("window minimum above window maximum");

    a_div_window : assert property (@(posedge clk) disable iff (!rst_n)
        div_status.busy |-> (state_reg == ST_DIV))
        else $error("divider running outside the divide step");

endmodule

`default_nettype wire

// File: rtl/tmf_divider.sv
`timescale 1ns / 1ps
`default_nettype none

module tmf_divider
    import tmf_pkg::*;
#(
    parameter int DW = 16,
    parameter int VW = 7
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [DW-1:0] dividend,
    input  wire logic [VW-1:0] divisor,
    output div_status_t        status,
    output logic [DW-1:0]      quotient
);

    localparam int CNT_W = $clog2(DW + 1);

    logic [VW-1:0]    rem_reg;
    logic [VW-1:0]    rem_next;
    logic [DW-1:0]    quo_reg;
    logic [DW-1:0]    quo_next;
    logic [VW-1:0]    dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             busy_reg;
    logic             busy_next;
    logic             done_reg;
    logic             done_next;
    logic [VW:0]      shifted;
    logic [VW:0]      trial;
    logic             borrow;

    // One restoring step per cycle: shift in the next dividend bit and try the subtraction.
    assign shifted = {rem_reg, quo_reg[DW-1]};
    assign trial   = shifted - {1'b0, dvs_reg};
    assign borrow  = trial[VW];

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = CNT_W'(DW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = borrow ? shifted[VW-1:0] : trial[VW-1:0];
            quo_next = {quo_reg[DW-2:0], ~borrow};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

    assign status.start = start;
    assign status.done  = done_reg;
    assign status.busy  = busy_reg;
    assign quotient     = quo_reg;

    a_start_busy : assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg)
        else $error("divider did not go busy after start");

    a_done_rem : assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (rem_reg < dvs_reg))
        else $error("divider remainder not below divisor");

    a_done_idle : assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider done while still busy");

endmodule

`default_nettype wire
